[design/bfsp_pkg.sv]
// shared types and codes for the bellman-ford shortest path block
package bfsp_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_FETCH,
        S_LOOK,
        S_RELAX,
        S_NEG,
        S_ORD,
        S_OUT
    } t_state;

    // configuration register indexes
    localparam logic CFG_VERTEX_COUNT  = 1'b0;
    localparam logic CFG_SOURCE_VERTEX = 1'b1;

    // input item kinds carried on tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

endpackage

[design/bfsp_ram.sv]
// generic single write port ram with one registered read port
module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/bellman_ford_shortest_paths.sv]
// top level of the bellman-ford shortest path engine
//
// Edges (from, to, signed weight) are loaded one per input beat with tuser low; a
// beat with tuser high starts a run from the configured source vertex. A load is
// dropped when the edge store is full or an endpoint is at or above vertex_count.
// A run resets the reach flags, then relaxes every stored edge in load order for
// up to vertex_count-1 passes (stopping early after a pass with no change), then
// makes one detection pass. All edges go through one shared add/compare unit; each
// edge is handled as an edge ram read, then a distance ram read, then a compare and
// write back. The result is either one beat with tuser (negative cycle) and tlast
// set and zero data, or one beat per vertex 0..vertex_count-1 with distance and a
// reachable flag, tlast on the final one. Unreachable vertices report distance 0.
// Distances are saturated on store but compared exactly. The edge store is emptied
// at the end of every run. The block takes no new beat until the last result beat
// is taken.
module bellman_ford_shortest_paths #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 64,
    parameter int WEIGHT_BITS  = 16,
    parameter int VW           = $clog2(MAX_VERTICES),
    parameter int DW           = WEIGHT_BITS + VW,
    parameter int IN_TW        = ((2 * VW + WEIGHT_BITS + 7) / 8) * 8,
    parameter int OUT_TW       = ((VW + DW + 1 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [VW:0]       i_cfg_data,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,   // edge_from, edge_to, edge_weight, zero pad
    input  logic              s_axis_tuser,   // action
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_TW-1:0] m_axis_tdata,   // vertex_index, distance, reachable, zero pad
    output logic              m_axis_tuser,   // negative_cycle
    output logic              m_axis_tlast
);

    import bfsp_pkg::*;

    localparam int EDW = 2 * VW + WEIGHT_BITS;                        // stored edge word
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;      // edge ram address
    localparam int ECW = $clog2(MAX_EDGES + 1);                        // edge count
    localparam int VN  = 1 << VW;                                      // reach flag slots
    localparam logic signed [DW:0] DIST_HI = {2'b00, {(DW - 1){1'b1}}};
    localparam logic signed [DW:0] DIST_LO = {2'b11, {(DW - 1){1'b0}}};

    // registers
    t_state          r_state, n_state;
    logic [VW:0]     r_vc, n_vc;
    logic [VW-1:0]   r_src, n_src;
    logic [ECW-1:0]  r_edge_count, n_edge_count;
    logic [ECW-1:0]  r_edge_idx, n_edge_idx;
    logic [VW:0]     r_pass, n_pass;
    logic            r_check, n_check;
    logic            r_changed, n_changed;
    logic [VN-1:0]   r_reach, n_reach;
    logic [VW-1:0]   r_out_idx, n_out_idx;

    // ram ports
    logic            w_edge_we;
    logic [EDW-1:0]  w_edge_q;
    logic            w_dist_we;
    logic [VW-1:0]   w_dist_waddr;
    logic [DW-1:0]   w_dist_wdata;
    logic [VW-1:0]   w_dist_raddr_a;
    logic [DW-1:0]   w_dist_qa;
    logic [DW-1:0]   w_dist_qb;

    // datapath
    logic [VW:0]          w_n;
    logic                 w_in_acc;
    logic [VW-1:0]        w_in_from;
    logic [VW-1:0]        w_in_to;
    logic                 w_load_ok;
    logic [VW-1:0]        w_eu;
    logic [VW-1:0]        w_ev;
    logic signed [WEIGHT_BITS-1:0] w_wt;
    logic signed [DW-1:0] w_du;
    logic signed [DW-1:0] w_dv;
    logic signed [DW:0]   w_cand;
    logic [DW-1:0]        w_sat;
    logic                 w_edge_live;
    logic                 w_relax;
    logic                 w_src_ok;
    logic                 w_out_last;

    // live vertex count, clamped to 1..MAX_VERTICES
    always_comb begin
        if (r_vc == '0) begin
            w_n = (VW + 1)'(1);
        end else if (r_vc > (VW + 1)'(MAX_VERTICES)) begin
            w_n = (VW + 1)'(MAX_VERTICES);
        end else begin
            w_n = r_vc;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_in_from     = s_axis_tdata[VW-1:0];
    assign w_in_to       = s_axis_tdata[2*VW-1:VW];
    assign w_load_ok     = (r_edge_count < ECW'(MAX_EDGES))
                        && ((VW + 1)'(w_in_from) < w_n)
                        && ((VW + 1)'(w_in_to) < w_n);
    assign w_edge_we     = w_in_acc && (s_axis_tuser == ACT_LOAD) && w_load_ok;
    assign w_src_ok      = (VW + 1)'(r_src) < w_n;

    // edge word fields, from lowest bit up
    assign w_eu = w_edge_q[VW-1:0];
    assign w_ev = w_edge_q[2*VW-1:VW];
    assign w_wt = $signed(w_edge_q[EDW-1:2*VW]);
    assign w_du = $signed(w_dist_qa);
    assign w_dv = $signed(w_dist_qb);

    // shared add/compare unit: exact sum, saturated on store
    assign w_cand = (DW + 1)'(w_du) + (DW + 1)'(w_wt);
    always_comb begin
        if (w_cand > DIST_HI) begin
            w_sat = DIST_HI[DW-1:0];
        end else if (w_cand < DIST_LO) begin
            w_sat = DIST_LO[DW-1:0];
        end else begin
            w_sat = w_cand[DW-1:0];
        end
    end

    // edges whose endpoints left the live range are skipped
    assign w_edge_live = ((VW + 1)'(w_eu) < w_n) && ((VW + 1)'(w_ev) < w_n) && r_reach[w_eu];
    assign w_relax     = w_edge_live && (!r_reach[w_ev] || (w_cand < (DW + 1)'(w_dv)));
    assign w_out_last  = ((VW + 1)'(r_out_idx) == (w_n - (VW + 1)'(1)));

    // distance port a reads the tail vertex while relaxing, the output vertex otherwise
    assign w_dist_raddr_a = ((r_state == S_ORD) || (r_state == S_OUT)) ? r_out_idx : w_eu;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_vc         = r_vc;
        n_src        = r_src;
        n_edge_count = r_edge_count;
        n_edge_idx   = r_edge_idx;
        n_pass       = r_pass;
        n_check      = r_check;
        n_changed    = r_changed;
        n_reach      = r_reach;
        n_out_idx    = r_out_idx;
        w_dist_we    = 1'b0;
        w_dist_waddr = w_ev;
        w_dist_wdata = w_sat;
        m_axis_tvalid = 1'b0;
        m_axis_tuser  = 1'b0;
        m_axis_tlast  = 1'b0;
        m_axis_tdata  = '0;

        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VERTEX_COUNT:  n_vc  = i_cfg_data;
                CFG_SOURCE_VERTEX: n_src = i_cfg_data[VW-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_edge_we) begin
                    n_edge_count = r_edge_count + ECW'(1);
                end
                if (w_in_acc && (s_axis_tuser == ACT_RUN)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                // only the source starts out reachable, at distance zero
                n_reach = '0;
                if (w_src_ok) begin
                    n_reach[r_src] = 1'b1;
                end
                w_dist_we    = w_src_ok;
                w_dist_waddr = r_src;
                w_dist_wdata = '0;
                n_pass       = (VW + 1)'(1);
                n_check      = (w_n == (VW + 1)'(1));
                n_changed    = 1'b0;
                n_edge_idx   = '0;
                n_state      = S_FETCH;
            end
            S_FETCH: begin
                if (r_edge_idx >= r_edge_count) begin
                    // end of a pass
                    n_edge_idx = '0;
                    n_changed  = 1'b0;
                    if (r_check) begin
                        n_edge_count = '0;
                        n_out_idx    = '0;
                        n_state      = r_changed ? S_NEG : S_ORD;
                    end else if (!r_changed || (r_pass == w_n - (VW + 1)'(1))) begin
                        n_check = 1'b1;
                    end else begin
                        n_pass = r_pass + (VW + 1)'(1);
                    end
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_RELAX;
            end
            S_RELAX: begin
                if (w_relax) begin
                    n_changed = 1'b1;
                    if (!r_check) begin
                        w_dist_we     = 1'b1;
                        n_reach[w_ev] = 1'b1;
                    end
                end
                n_edge_idx = r_edge_idx + ECW'(1);
                n_state    = S_FETCH;
            end
            S_NEG: begin
                m_axis_tvalid = 1'b1;
                m_axis_tuser  = 1'b1;
                m_axis_tlast  = 1'b1;
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            S_ORD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = w_out_last;
                m_axis_tdata  = OUT_TW'({r_reach[r_out_idx],
                                         r_reach[r_out_idx] ? w_dist_qa : {DW{1'b0}},
                                         r_out_idx});
                if (m_axis_tready) begin
                    if (w_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_out_idx = r_out_idx + VW'(1);
                        n_state   = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vc         <= (VW + 1)'(MAX_VERTICES);
            r_src        <= '0;
            r_edge_count <= '0;
            r_reach      <= '0;
            r_check      <= 1'b0;
            r_changed    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_vc         <= n_vc;
            r_src        <= n_src;
            r_edge_count <= n_edge_count;
            r_reach      <= n_reach;
            r_check      <= n_check;
            r_changed    <= n_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge_idx <= n_edge_idx;
        r_pass     <= n_pass;
        r_out_idx  <= n_out_idx;
    end

    // edge store, written at the fill count, read at the current edge
    bfsp_ram #(
        .WIDTH (EDW),
        .DEPTH (MAX_EDGES),
        .AW    (EAW)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_edge_we),
        .i_waddr (r_edge_count[EAW-1:0]),
        .i_wdata (s_axis_tdata[EDW-1:0]),
        .i_raddr (r_edge_idx[EAW-1:0]),
        .o_rdata (w_edge_q)
    );

    // two copies of the distance table, one read at the tail and one at the head
    bfsp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES),
        .AW    (VW)
    ) u_dist_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_dist_we),
        .i_waddr (w_dist_waddr),
        .i_wdata (w_dist_wdata),
        .i_raddr (w_dist_raddr_a),
        .o_rdata (w_dist_qa)
    );

    bfsp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES),
        .AW    (VW)
    ) u_dist_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_dist_we),
        .i_waddr (w_dist_waddr),
        .i_wdata (w_dist_wdata),
        .i_raddr (w_ev),
        .o_rdata (w_dist_qb)
    );

endmodule
